// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

    // list storage
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // payload field widths
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // width for comparing positions against the element count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // stream data widths, rounded up to whole bytes
    localparam int S_DATA_BITS = VAL_W + POS_W;
    localparam int M_DATA_BITS = COUNT_W + 3 * VAL_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input transfer
        logic exec;    // apply the operation to the cell chain
        logic finish;  // load the result register
    } bdq_cmd_t;

endpackage

// ===== rtl/bdq_ctrl.sv =====
module bdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bdq_pkg::bdq_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIN  = 3'b100
    } bdq_state_t;

    bdq_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // result register can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/bdq_datapath.sv =====
module bdq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bdq_pkg::bdq_cmd_t                   cmd,
    input  logic        [bdq_pkg::OP_W-1:0]     in_op,
    input  logic signed [bdq_pkg::VAL_W-1:0]    in_val,
    input  logic        [bdq_pkg::POS_W-1:0]    in_pos,
    output logic        [bdq_pkg::STAT_W-1:0]   out_status,
    output logic        [bdq_pkg::COUNT_W-1:0]  out_count,
    output logic signed [bdq_pkg::VAL_W-1:0]    out_front,
    output logic signed [bdq_pkg::VAL_W-1:0]    out_back,
    output logic signed [bdq_pkg::VAL_W-1:0]    out_read
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int IDX_W = bdq_pkg::IDX_W;
    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int CMP_W = bdq_pkg::CMP_W;
    localparam int VAL_W = bdq_pkg::VAL_W;

    // cell chain, entry 0 is the front
    logic signed [VAL_W-1:0] cells_reg [DEPTH];
    logic signed [VAL_W-1:0] from_prev [DEPTH];
    logic signed [VAL_W-1:0] from_next [DEPTH];

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [bdq_pkg::OP_W-1:0]  op_reg;
    logic signed [VAL_W-1:0]   val_reg;
    logic [bdq_pkg::POS_W-1:0] pos_reg;
    logic [bdq_pkg::STAT_W-1:0] status_reg;
    logic signed [VAL_W-1:0]   rd_reg;

    logic [CMP_W-1:0]          pos_ext, cnt_ext, back_pos, at;
    logic                      empty, full, place, ins, rem, rd_en;
    logic [bdq_pkg::STAT_W-1:0] st;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [VAL_W-1:0]   rd_data;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign back_pos = cnt_ext - CMP_W'(1);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

    // operation decode
    always_comb begin
        at    = '0;
        place = 1'b0;
        ins   = 1'b0;
        rem   = 1'b0;
        rd_en = 1'b0;
        st    = bdq_pkg::STAT_OK;
        unique case (op_reg)
            bdq_pkg::OP_PUSH_FRONT: begin
                at    = '0;
                place = 1'b1;
            end
            bdq_pkg::OP_PUSH_BACK: begin
                at    = cnt_ext;
                place = 1'b1;
            end
            bdq_pkg::OP_INSERT: begin
                at    = pos_ext;
                place = 1'b1;
            end
            bdq_pkg::OP_POP_FRONT: begin
                at = '0;
                if (empty) begin
                    st = bdq_pkg::STAT_EMPTY;
                end else begin
                    rem   = 1'b1;
                    rd_en = 1'b1;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                at = back_pos;
                if (empty) begin
                    st = bdq_pkg::STAT_EMPTY;
                end else begin
                    rem   = 1'b1;
                    rd_en = 1'b1;
                end
            end
            bdq_pkg::OP_READ: begin
                at = pos_ext;
                if (empty) begin
                    st = bdq_pkg::STAT_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    st = bdq_pkg::STAT_INDEX;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                at = '0;
            end
        endcase
        // index check ahead of the full check
        if (place) begin
            if (at > cnt_ext) begin
                st = bdq_pkg::STAT_INDEX;
            end else if (full) begin
                st = bdq_pkg::STAT_FULL;
            end else begin
                ins = 1'b1;
            end
        end
    end

    // single read port: operation position during exec, back during finish
    assign rd_addr = cmd.exec ? at[IDX_W-1:0] : back_pos[IDX_W-1:0];
    assign rd_data = cells_reg[rd_addr];

    always_comb begin
        count_next = count_reg;
        if (cmd.exec && ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.exec && rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // neighbour taps for shifting
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign from_prev[g] = val_reg;
        end else begin : g_mid
            assign from_prev[g] = cells_reg[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign from_next[g] = cells_reg[g];
        end else begin : g_rest
            assign from_next[g] = cells_reg[g+1];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (cmd.exec) begin
                if (ins && (CMP_W'(g) == at)) begin
                    cells_reg[g] <= val_reg;
                end else if (ins && (CMP_W'(g) > at)) begin
                    cells_reg[g] <= from_prev[g];
                end else if (rem && (CMP_W'(g) >= at)) begin
                    cells_reg[g] <= from_next[g];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            val_reg <= in_val;
            pos_reg <= in_pos;
        end
        if (cmd.exec) begin
            status_reg <= st;
            rd_reg     <= rd_en ? rd_data : '0;
        end
        if (cmd.finish) begin
            out_status <= status_reg;
            out_count  <= bdq_pkg::COUNT_W'(count_reg);
            out_front  <= empty ? '0 : cells_reg[0];
            out_back   <= empty ? '0 : rd_data;
            out_read   <= rd_reg;
        end
    end

endmodule

// ===== rtl/bounded_deque_with_insert.sv =====
// Bounded deque with positional insert, DEPTH entries in a shifting cell chain.
// Sequence: the input transfer is captured, then the execute and finish states
//   follow; finish loads the result register and waits while it is still held.
// A new item is taken only after the previous one has finished; an item
//   may be taken while the previous result still waits on the output register.
// Reset: aresetn synchronous active low; clears element count, controller and
//   output valid. Cell contents are not reset.
module bounded_deque_with_insert (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0]     s_tdata,  // value[31:0], position[36:32]
    input  logic [bdq_pkg::OP_W-1:0]          s_tuser,  // operation[2:0]
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0]     m_tdata,  // count[4:0], front_value[36:5],
                                                        // back_value[68:37], read_value[100:69]
    output logic [bdq_pkg::STAT_W-1:0]        m_tuser   // status[1:0]
);

    localparam int VAL_W   = bdq_pkg::VAL_W;
    localparam int POS_W   = bdq_pkg::POS_W;
    localparam int COUNT_W = bdq_pkg::COUNT_W;
    localparam int PAD_W   = bdq_pkg::M_TDATA_W - bdq_pkg::M_DATA_BITS;

    bdq_pkg::bdq_cmd_t              cmd;
    logic signed [VAL_W-1:0]        in_val;
    logic        [POS_W-1:0]        in_pos;
    logic        [bdq_pkg::STAT_W-1:0] res_status;
    logic        [COUNT_W-1:0]      res_count;
    logic signed [VAL_W-1:0]        res_front, res_back, res_read;

    // unpack input transfer
    assign in_val = s_tdata[VAL_W-1:0];
    assign in_pos = s_tdata[VAL_W +: POS_W];

    // sequencer: capture, execute, finish
    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // cell chain, count and result register
    bdq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_op      (s_tuser),
        .in_val     (in_val),
        .in_pos     (in_pos),
        .out_status (res_status),
        .out_count  (res_count),
        .out_front  (res_front),
        .out_back   (res_back),
        .out_read   (res_read)
    );

    // pack result transfer, zero fill to whole bytes
    assign m_tdata = {{PAD_W{1'b0}}, res_read, res_back, res_front, res_count};
    assign m_tuser = res_status;

    // a full refusal always reports a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bdq_pkg::STAT_FULL)) |->
            (res_count == COUNT_W'(bdq_pkg::DEPTH)))
        else $error("full status with count below depth");

    // an empty list shows zero front and back
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_count == '0)) |-> ((res_front == '0) && (res_back == '0)))
        else $error("empty list with non-zero front or back");

    // failed operations return no read data
    a_fail_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != bdq_pkg::STAT_OK)) |-> (res_read == '0))
        else $error("read value on failed operation");

    // one item in flight: no transfer straight after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && cmd.exec))
        else $error("item accepted while one is in execution");

endmodule
